@@ rtl/text_console_writer_assert.svh @@
// Assertion macros for the text console writer.
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication under a synchronous reset.
`define TCW_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication under a synchronous reset.
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define TCW_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

@@ rtl/tcw_pkg.sv @@
// Shared types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

   // default screen geometry
   localparam int COLUMNS_DEF = 80;
   localparam int ROWS_DEF    = 25;

   // character and attribute codes
   localparam logic [7:0]  NEWLINE_CODE = 8'h0A;
   localparam logic [7:0]  SPACE_CODE   = 8'h20;
   localparam logic [7:0]  RESET_COLOUR = 8'h0F;
   localparam logic [15:0] RESET_BLANK  = {RESET_COLOUR, SPACE_CODE};

   // action codes
   localparam logic [1:0] ACT_PUT   = 2'd0;
   localparam logic [1:0] ACT_CLEAR = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;

   // request word
   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  char_code;
      logic [10:0] cell_index;
   } req_type;

   // result word
   typedef struct packed {
      logic [10:0] cursor_pos;
      logic [15:0] cell_data;
   } rsp_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_SCROLL,
      ST_DRAIN,
      ST_FILL
   } state_type;

endpackage

`default_nettype wire

@@ rtl/tcw_screen_ram.sv @@
// Screen store: one write port, one registered read port.
`default_nettype none

module tcw_screen_ram #(
   parameter int CELLS  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
   parameter int ADDR_W = $clog2(CELLS)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [15:0]       wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [15:0]       rd_data
);

   logic [15:0] store_ff [CELLS];
   logic [15:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/tcw_ctrl.sv @@
// Sequencer: cursor, colour register, scroll copy, fills and result word.
`default_nettype none

module tcw_ctrl #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF,
   parameter int CELLS   = COLUMNS * ROWS,
   parameter int ADDR_W  = $clog2(CELLS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire tcw_pkg::req_type  req_data,
   output logic                   rsp_valid,
   output tcw_pkg::rsp_type       rsp_data,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [7:0]        csr_data,
   output logic                   mem_wr_en,
   output logic [ADDR_W-1:0]      mem_wr_addr,
   output logic [15:0]            mem_wr_data,
   output logic [ADDR_W-1:0]      mem_rd_addr,
   input  wire logic [15:0]       mem_rd_data
);

   localparam int COL_W = $clog2(COLUMNS);
   localparam int ROW_W = $clog2(ROWS);
   localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
   localparam logic [ADDR_W-1:0] LAST_ROW0 = ADDR_W'((ROWS - 1) * COLUMNS);
   localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLUMNS);
   localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);

   tcw_pkg::state_type state_ff, state_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0]  wb_ff, wb_in;
   logic               pend_ff, pend_in;
   logic               range_ff, range_in;
   logic [7:0]         colour_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   tcw_pkg::rsp_type   rsp_ff, rsp_in;
   logic [15:0]        cell_data_in;
   logic [ADDR_W-1:0]  cur_pos;
   logic [ADDR_W-1:0]  next_pos;
   logic [15:0]        blank;

   // colour register, always writable
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         colour_ff <= tcw_pkg::RESET_COLOUR;
      end else if (csr_valid) begin
         colour_ff <= csr_data;
      end
   end

   assign blank   = {colour_ff, tcw_pkg::SPACE_CODE};
   assign cur_pos = ADDR_W'(row_ff) * ROW_STEP + ADDR_W'(col_ff);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_INIT;
         col_ff       <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      wb_ff    <= wb_in;
      range_ff <= range_in;
      rsp_ff   <= rsp_in;
   end

   // next state and memory control
   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      cnt_in       = cnt_ff;
      wb_in        = wb_ff;
      pend_in      = 1'b0;
      range_in     = range_ff;
      rsp_valid_in = 1'b0;
      cell_data_in = '0;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = cur_pos;
      mem_wr_data  = blank;
      mem_rd_addr  = cnt_ff;

      case (state_ff)
         // blank the store after reset with the reset attribute
         tcw_pkg::ST_INIT: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff;
            mem_wr_data = tcw_pkg::RESET_BLANK;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CELL) begin
               cnt_in   = '0;
               state_in = tcw_pkg::ST_IDLE;
            end
         end
         tcw_pkg::ST_IDLE: begin
            if (start) begin
               case (req_data.action)
                  tcw_pkg::ACT_PUT: begin
                     if (req_data.char_code != tcw_pkg::NEWLINE_CODE) begin
                        mem_wr_en   = 1'b1;
                        mem_wr_data = {colour_ff, req_data.char_code};
                     end
                     if (req_data.char_code == tcw_pkg::NEWLINE_CODE ||
                         col_ff == LAST_COL) begin
                        col_in = '0;
                        if (row_ff == LAST_ROW) begin
                           // past the last row: move everything up one row
                           cnt_in   = ROW_STEP;
                           state_in = tcw_pkg::ST_SCROLL;
                        end else begin
                           row_in       = row_ff + 1'b1;
                           rsp_valid_in = 1'b1;
                        end
                     end else begin
                        col_in       = col_ff + 1'b1;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  tcw_pkg::ACT_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     cnt_in   = '0;
                     state_in = tcw_pkg::ST_FILL;
                  end
                  tcw_pkg::ACT_READ: begin
                     mem_rd_addr = ADDR_W'(req_data.cell_index);
                     range_in    = (32'(req_data.cell_index) < 32'(CELLS));
                     state_in    = tcw_pkg::ST_READ;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         // read data is back from the store
         tcw_pkg::ST_READ: begin
            rsp_valid_in = 1'b1;
            cell_data_in = range_ff ? mem_rd_data : 16'h0000;
            state_in     = tcw_pkg::ST_IDLE;
         end
         // copy cell cnt to cnt - COLUMNS, write follows the read in the next cycle
         tcw_pkg::ST_SCROLL: begin
            mem_rd_addr = cnt_ff;
            mem_wr_en   = pend_ff;
            mem_wr_addr = wb_ff;
            mem_wr_data = mem_rd_data;
            pend_in     = 1'b1;
            wb_in       = cnt_ff - ROW_STEP;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CELL) begin
               state_in = tcw_pkg::ST_DRAIN;
            end
         end
         // last copied cell, then blank the bottom row
         tcw_pkg::ST_DRAIN: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = wb_ff;
            mem_wr_data = mem_rd_data;
            cnt_in      = LAST_ROW0;
            state_in    = tcw_pkg::ST_FILL;
         end
         // blank from cnt to the end of the store
         tcw_pkg::ST_FILL: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = cnt_ff;
            mem_wr_data = blank;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == LAST_CELL) begin
               cnt_in       = '0;
               rsp_valid_in = 1'b1;
               state_in     = tcw_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

   // cursor position after this cycle's update
   assign next_pos = ADDR_W'(row_in) * ROW_STEP + ADDR_W'(col_in);
   assign rsp_in   = '{cursor_pos: 11'(next_pos), cell_data: cell_data_in};

   assign busy      = (state_ff != tcw_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/text_console_writer.sv @@
// Top level of the text console writer: sequencer plus screen store.
`default_nettype none

// Character-cell console over a COLUMNS x ROWS store of attribute/character
// words. An action is taken when start is high and busy is low; every action
// gives one result word on rsp_data, marked by rsp_valid for one cycle, and the
// receiver cannot stall it. A plain put or an unused action answers in the next
// cycle, a read after its READ state and the store's registered read port. A put
// that runs past the last row scrolls: the store is copied through its single
// read and write port one cell a cycle, then the bottom row is blanked. A clear
// blanks every cell at one cell a cycle. After reset busy stays high while the
// store is blanked; the colour register can be written at any time and is
// always ready.
module text_console_writer #(
   parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
   parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire tcw_pkg::req_type req_data,
   output logic                  rsp_valid,
   output tcw_pkg::rsp_type      rsp_data,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [7:0]       csr_data
);

`include "text_console_writer_assert.svh"

   localparam int CELLS  = COLUMNS * ROWS;
   localparam int ADDR_W = $clog2(CELLS);

   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   logic [15:0]       mem_wr_data;
   logic [ADDR_W-1:0] mem_rd_addr;
   logic [15:0]       mem_rd_data;

   // sequencer
   tcw_ctrl #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS),
      .CELLS   (CELLS),
      .ADDR_W  (ADDR_W)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // screen store
   tcw_screen_ram #(
      .CELLS  (CELLS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // an accepted action is either answered next cycle or keeps the block busy
   `TCW_ASSERT_NEXT(a_accept_progress, clock, reset, start && !busy, busy || rsp_valid, "accepted action neither answered nor busy")
   // a result is only shown once the sequencer is back to idle
   `TCW_ASSERT_IMPL(a_rsp_idle, clock, reset, rsp_valid, !busy, "result word while busy")
   // store writes stay inside the screen
   `TCW_ASSERT_IMPL(a_wr_range, clock, reset, mem_wr_en, 32'(mem_wr_addr) < 32'(CELLS), "store write out of range")

endmodule

`default_nettype wire

@@ verif/console_screen_checker.sv @@
// Checker for the text console writer: tracks the screen, predicts each result word, compares.
`timescale 1ns / 1ps

module console_screen_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  tcw_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  tcw_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [7:0]       csr_data,
   output int               mismatches,
   output int               awaited,
   output int               results_seen,
   output int               scrolls
);

   localparam int CELL_COUNT = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF;

   // shadow of the screen store, cursor and attribute register
   logic [15:0]      screen [CELL_COUNT];
   int unsigned      cur_col;
   int unsigned      cur_row;
   logic [7:0]       text_attr;
   tcw_pkg::rsp_type awaited_words [$];
   int               err_total;
   int               seen_total;
   int               scroll_total;

   function automatic logic [15:0] blank_cell();
      return {text_attr, tcw_pkg::SPACE_CODE};
   endfunction

   // move every row up one, blank the bottom row, pin the cursor to it
   function automatic void scroll_screen();
      for (int i = tcw_pkg::COLUMNS_DEF; i < CELL_COUNT; i++)
         screen[i - tcw_pkg::COLUMNS_DEF] = screen[i];
      for (int i = CELL_COUNT - tcw_pkg::COLUMNS_DEF; i < CELL_COUNT; i++)
         screen[i] = blank_cell();
      cur_row = tcw_pkg::ROWS_DEF - 1;
      scroll_total++;
   endfunction

   // apply one request word to the shadow state, return the result word it gives
   function automatic tcw_pkg::rsp_type console_action(tcw_pkg::req_type w);
      tcw_pkg::rsp_type r;
      int unsigned      addr;
      r = '0;
      case (w.action)
         tcw_pkg::ACT_PUT: begin
            if (w.char_code == tcw_pkg::NEWLINE_CODE) begin
               cur_col = 0;
               cur_row++;
            end else begin
               addr = cur_row * tcw_pkg::COLUMNS_DEF + cur_col;
               if (addr < CELL_COUNT)
                  screen[addr] = {text_attr, w.char_code};
               cur_col++;
               // wrap at the row end
               if (cur_col >= tcw_pkg::COLUMNS_DEF) begin
                  cur_col = 0;
                  cur_row++;
               end
            end
            if (cur_row >= tcw_pkg::ROWS_DEF)
               scroll_screen();
         end
         tcw_pkg::ACT_CLEAR: begin
            foreach (screen[i])
               screen[i] = blank_cell();
            cur_col = 0;
            cur_row = 0;
         end
         tcw_pkg::ACT_READ: begin
            // out-of-range reads give zero
            if (w.cell_index < CELL_COUNT)
               r.cell_data = screen[w.cell_index];
         end
         default: begin
            // unused action: cursor only
         end
      endcase
      r.cursor_pos = 11'(cur_row * tcw_pkg::COLUMNS_DEF + cur_col);
      return r;
   endfunction

   always @(posedge clock) begin
      tcw_pkg::rsp_type want;
      if (reset) begin
         foreach (screen[i])
            screen[i] = tcw_pkg::RESET_BLANK;
         cur_col      = 0;
         cur_row      = 0;
         text_attr    = tcw_pkg::RESET_COLOUR;
         err_total    = 0;
         seen_total   = 0;
         scroll_total = 0;
         awaited_words.delete();
      end else begin
         // attribute write
         if (csr_valid && csr_ready)
            text_attr = csr_data;
         // result word against the oldest prediction
         if (rsp_valid) begin
            if (awaited_words.size() == 0) begin
               $error("result word with nothing awaited: cursor_pos %0d cell_data %h",
                      rsp_data.cursor_pos, rsp_data.cell_data);
               err_total++;
            end else begin
               want = awaited_words.pop_front();
               seen_total++;
               if (rsp_data.cursor_pos !== want.cursor_pos) begin
                  $error("cursor_pos: expected %0d, actual %0d",
                         want.cursor_pos, rsp_data.cursor_pos);
                  err_total++;
               end
               if (rsp_data.cell_data !== want.cell_data) begin
                  $error("cell_data: expected %h, actual %h",
                         want.cell_data, rsp_data.cell_data);
                  err_total++;
               end
            end
         end
         // accepted request word
         if (start && !busy)
            awaited_words.push_back(console_action(req_data));
      end
      mismatches   <= err_total;
      awaited      <= awaited_words.size();
      results_seen <= seen_total;
      scrolls      <= scroll_total;
   end

endmodule

@@ verif/tb_text_console_writer.sv @@
// Testbench top for the text console writer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_text_console_writer;

   localparam logic [1:0] ACT_UNUSED   = 2'd3;
   localparam int         CELL_COUNT   = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF;
   localparam int         RANDOM_WORDS = 1150;
   localparam int         PHASES       = 6;

   logic             clock;
   logic             reset;
   logic             start;
   logic             busy;
   tcw_pkg::req_type req_data;
   logic             rsp_valid;
   tcw_pkg::rsp_type rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [7:0]       csr_data;

   int mismatches;
   int awaited;
   int results_seen;
   int scrolls;
   int words_sent;
   int clears_sent;
   int attr_writes;
   bit gaps_on;

   text_console_writer dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   console_screen_checker u_screen_check (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_data     (rsp_data),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_data     (csr_data),
      .mismatches   (mismatches),
      .awaited      (awaited),
      .results_seen (results_seen),
      .scrolls      (scrolls)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // hard stop well past the slowest legal run
   initial begin
      #25_000_000;
      $display("text_console_writer regression: fail");
      $finish;
   end

   // present one request word and hold it until taken
   task automatic send_word(input logic [1:0] act, input logic [7:0] code,
                            input logic [10:0] idx);
      @(negedge clock);
      start    <= 1'b1;
      req_data <= '{action: act, char_code: code, cell_index: idx};
      do @(posedge clock); while (busy);
      words_sent++;
      if (act == tcw_pkg::ACT_CLEAR)
         clears_sent++;
   endtask

   // random sender gaps, started before about 6 words in 100
   task automatic sender_gap();
      while (gaps_on && $urandom_range(99) < 6) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   // stop sending and wait until every result is in and the block is idle
   task automatic settle();
      @(negedge clock);
      start <= 1'b0;
      while (awaited != 0 || busy)
         @(negedge clock);
   endtask

   task automatic write_attr(input logic [7:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      attr_writes++;
   endtask

   // one random word; counted is low for the unused action
   task automatic random_word(input int put_pct, input int nl_pct, output bit counted);
      int          pick;
      int          spread;
      logic [7:0]  code;
      logic [10:0] idx;
      pick   = $urandom_range(999);
      spread = $urandom_range(99);
      code   = 8'($urandom_range(255));
      // mostly in range, some on the bottom row and past the end
      if (spread < 70)
         idx = 11'($urandom_range(CELL_COUNT - 1));
      else if (spread < 85)
         idx = 11'($urandom_range(2047, CELL_COUNT - tcw_pkg::COLUMNS_DEF));
      else
         idx = 11'($urandom_range(2047));
      counted = 1'b1;
      if (pick < put_pct * 10) begin
         if ($urandom_range(99) < nl_pct)
            code = tcw_pkg::NEWLINE_CODE;
         send_word(tcw_pkg::ACT_PUT, code, idx);
      end else if (pick < put_pct * 10 + 3) begin
         send_word(tcw_pkg::ACT_CLEAR, code, idx);
      end else if (pick < put_pct * 10 + 33) begin
         send_word(ACT_UNUSED, code, idx);
         counted = 1'b0;
      end else begin
         send_word(tcw_pkg::ACT_READ, code, idx);
      end
   endtask

   initial begin
      int         counted_words;
      int         put_pct;
      int         nl_pct;
      int         waited;
      bit         counted;
      logic [7:0] phase_attr;

      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_valid   = 1'b0;
      csr_data    = '0;
      gaps_on     = 1'b1;
      words_sent  = 0;
      clears_sent = 0;
      attr_writes = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reads at the ends of the index range under the reset attribute
      send_word(tcw_pkg::ACT_READ, 8'h00, 11'd0);
      send_word(tcw_pkg::ACT_READ, 8'hFF, 11'h7FF);
      send_word(tcw_pkg::ACT_READ, 8'h00, 11'(CELL_COUNT));
      send_word(tcw_pkg::ACT_READ, 8'h00, 11'(CELL_COUNT - 1));
      // character extremes, then the unused action and readback
      send_word(tcw_pkg::ACT_PUT, 8'h41, 11'h7FF);
      send_word(tcw_pkg::ACT_PUT, 8'hFF, 11'd0);
      send_word(tcw_pkg::ACT_PUT, 8'h00, 11'd0);
      send_word(ACT_UNUSED, 8'hFF, 11'h7FF);
      send_word(tcw_pkg::ACT_READ, 8'h00, 11'd1);
      send_word(tcw_pkg::ACT_PUT, tcw_pkg::NEWLINE_CODE, 11'd0);
      send_word(tcw_pkg::ACT_READ, 8'h00, 11'd3);
      settle();
      // zero attribute: written cell, then blanks from a clear
      write_attr(8'h00);
      send_word(tcw_pkg::ACT_PUT, 8'h7E, 11'd0);
      send_word(tcw_pkg::ACT_READ, 8'h00, 11'(tcw_pkg::COLUMNS_DEF));
      send_word(tcw_pkg::ACT_CLEAR, 8'h00, 11'd0);
      send_word(tcw_pkg::ACT_READ, 8'h00, 11'(tcw_pkg::COLUMNS_DEF));
      settle();
      write_attr(8'hFF);
      send_word(tcw_pkg::ACT_CLEAR, 8'hFF, 11'h7FF);
      send_word(tcw_pkg::ACT_READ, 8'h00, 11'(CELL_COUNT - 1));
      settle();

      // random phases, each under its own attribute and text shape
      counted_words = 0;
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: begin
               phase_attr = 8'h00;
               put_pct = 60; nl_pct = 25;
            end
            1: begin
               phase_attr = 8'hFF;
               put_pct = 90; nl_pct = 1;
            end
            2: begin
               phase_attr = 8'($urandom_range(255));
               put_pct = 60; nl_pct = 25;
            end
            3: begin
               phase_attr = 8'($urandom_range(255));
               put_pct = 90; nl_pct = 1;
            end
            4: begin
               phase_attr = tcw_pkg::RESET_COLOUR;
               put_pct = 60; nl_pct = 15;
            end
            default: begin
               phase_attr = 8'($urandom_range(255));
               put_pct = 75; nl_pct = 5;
            end
         endcase
         // one phase runs back to back with no sender gaps
         gaps_on = (ph != 2);
         write_attr(phase_attr);
         while (counted_words < RANDOM_WORDS * (ph + 1) / PHASES) begin
            sender_gap();
            random_word(put_pct, nl_pct, counted);
            if (counted)
               counted_words++;
         end
         settle();
      end

      // drain, then a short quiet spell for stray results
      @(negedge clock);
      start  <= 1'b0;
      waited = 0;
      while ((awaited != 0 || busy) && waited < 20000) begin
         @(negedge clock);
         waited++;
      end
      repeat (20) @(negedge clock);

      $display("covered %0d request words (%0d clears) over %0d attribute settings",
               words_sent, clears_sent, attr_writes);
      $display("checked %0d result words across %0d scrolls", results_seen, scrolls);
      if (awaited != 0)
         $error("%0d result words never arrived", awaited);
      if (mismatches == 0 && awaited == 0) begin
         $display("text_console_writer regression: pass");
      end else begin
         $display("text_console_writer regression: fail");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/tcw_pkg.sv
rtl/tcw_screen_ram.sv
rtl/tcw_ctrl.sv
rtl/text_console_writer.sv
verif/console_screen_checker.sv
verif/tb_text_console_writer.sv
